// File: src/htdps_pkg.sv
// shared types and constants for the depth-preferred hash table store
// no dependencies
`default_nettype none
package htdps_pkg;

   localparam int INDEX_BITS = 12;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;
   localparam int KEY_W = 64;
   localparam int TAG_W = 16;
   localparam int FLAG_W = 2;
   localparam int MOVE_W = 16;
   localparam int DEPTH_W = 8;
   localparam int SCORE_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_PROBE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXACT_FLAG = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_MOVE = 1'd1;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [FLAG_W-1:0] flag;
      logic [MOVE_W-1:0] move;
      logic [DEPTH_W-1:0] depth;
      logic signed [SCORE_W-1:0] score;
      logic signed [SCORE_W-1:0] eval;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic capture;
      logic clr_write;
      logic commit_store;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_probe;
      logic clr_last;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: src/hash_table_depth_preferred_store_core.sv
// top level of the depth-preferred hash table store
// depends on htdps_pkg, htdps_ctrl, htdps_dp (which holds htdps_ram)
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cmd, key, flag, move, depth, score, eval
//   rsp      out        rsp_valid/rsp_stall  hit, entry fields, hit_move
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// an item passes accept, registered ram read and update; req stalls in read and update
// a probe holds in update while an earlier result is still stalled on rsp
// after reset a clearing pass writes zeros to all 4096 entries, req stalled
// csr writes are taken in every cycle, the clearing pass included
`default_nettype none
module hash_table_depth_preferred_store_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_cmd,
   input  wire logic [htdps_pkg::KEY_W-1:0]           req_key,
   input  wire logic [htdps_pkg::FLAG_W-1:0]          req_bound_flag,
   input  wire logic [htdps_pkg::MOVE_W-1:0]          req_best_move,
   input  wire logic [htdps_pkg::DEPTH_W-1:0]         req_search_depth,
   input  wire logic signed [htdps_pkg::SCORE_W-1:0]  req_score_value,
   input  wire logic signed [htdps_pkg::SCORE_W-1:0]  req_static_eval,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic [htdps_pkg::FLAG_W-1:0]               rsp_entry_flag,
   output logic [htdps_pkg::MOVE_W-1:0]               rsp_entry_move,
   output logic [htdps_pkg::MOVE_W-1:0]               rsp_hit_move,
   output logic [htdps_pkg::DEPTH_W-1:0]              rsp_entry_depth,
   output logic signed [htdps_pkg::SCORE_W-1:0]       rsp_entry_score,
   output logic signed [htdps_pkg::SCORE_W-1:0]       rsp_entry_eval,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [htdps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [htdps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   htdps_pkg::dp_cmd_type    cmd;
   htdps_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   htdps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   htdps_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_bound_flag   (req_bound_flag),
      .req_best_move    (req_best_move),
      .req_search_depth (req_search_depth),
      .req_score_value  (req_score_value),
      .req_static_eval  (req_static_eval),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_entry_flag   (rsp_entry_flag),
      .rsp_entry_move   (rsp_entry_move),
      .rsp_hit_move     (rsp_hit_move),
      .rsp_entry_depth  (rsp_entry_depth),
      .rsp_entry_score  (rsp_entry_score),
      .rsp_entry_eval   (rsp_entry_eval),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule
`default_nettype wire

// File: src/htdps_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module htdps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/htdps_ctrl.sv
// controller state machine: clearing pass, accept, read, update
// depends on htdps_pkg
`default_nettype none
module htdps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire htdps_pkg::dp_status_type status,
   output htdps_pkg::dp_cmd_type        cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!status.is_probe) begin
               cmd.commit_store = 1'b1;
               state_in = ST_IDLE;
            end else if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: src/htdps_dp.sv
// datapath: request latch, config registers, table ram, replacement and result register
// depends on htdps_pkg and htdps_ram
`default_nettype none
module htdps_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire htdps_pkg::dp_cmd_type                 cmd,
   output htdps_pkg::dp_status_type                   status,
   input  wire logic                                  req_cmd,
   input  wire logic [htdps_pkg::KEY_W-1:0]           req_key,
   input  wire logic [htdps_pkg::FLAG_W-1:0]          req_bound_flag,
   input  wire logic [htdps_pkg::MOVE_W-1:0]          req_best_move,
   input  wire logic [htdps_pkg::DEPTH_W-1:0]         req_search_depth,
   input  wire logic signed [htdps_pkg::SCORE_W-1:0]  req_score_value,
   input  wire logic signed [htdps_pkg::SCORE_W-1:0]  req_static_eval,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic [htdps_pkg::FLAG_W-1:0]               rsp_entry_flag,
   output logic [htdps_pkg::MOVE_W-1:0]               rsp_entry_move,
   output logic [htdps_pkg::MOVE_W-1:0]               rsp_hit_move,
   output logic [htdps_pkg::DEPTH_W-1:0]              rsp_entry_depth,
   output logic signed [htdps_pkg::SCORE_W-1:0]       rsp_entry_score,
   output logic signed [htdps_pkg::SCORE_W-1:0]       rsp_entry_eval,
   input  wire logic                                  csr_write,
   input  wire logic [htdps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [htdps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic                                  cmd_ff;
   logic [htdps_pkg::INDEX_BITS-1:0]      index_ff;
   htdps_pkg::entry_type                  new_ff;
   logic [htdps_pkg::FLAG_W-1:0]          exact_flag_ff;
   logic [htdps_pkg::MOVE_W-1:0]          no_move_ff;
   logic [htdps_pkg::INDEX_BITS-1:0]      clr_ff;
   logic                                  rsp_valid_ff;
   htdps_pkg::entry_type                  rsp_entry_ff;
   logic                                  rsp_hit_ff;
   logic [htdps_pkg::MOVE_W-1:0]          rsp_hit_move_ff;

   htdps_pkg::entry_type                  stored;
   htdps_pkg::entry_type                  merged;
   logic [htdps_pkg::ENTRY_W-1:0]         rd_data;
   logic [htdps_pkg::ENTRY_W-1:0]         wr_data;
   logic [htdps_pkg::INDEX_BITS-1:0]      wr_addr;
   logic                                  same;
   logic                                  full_write;
   logic                                  move_write;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         index_ff <= req_key[htdps_pkg::KEY_W-1 -: htdps_pkg::INDEX_BITS];
         new_ff.tag <= req_key[htdps_pkg::TAG_W-1:0];
         new_ff.flag <= req_bound_flag;
         new_ff.move <= req_best_move;
         new_ff.depth <= req_search_depth;
         new_ff.score <= req_score_value;
         new_ff.eval <= req_static_eval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exact_flag_ff <= '0;
         no_move_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            htdps_pkg::CSR_EXACT_FLAG: exact_flag_ff <= csr_wdata[htdps_pkg::FLAG_W-1:0];
            htdps_pkg::CSR_NO_MOVE:    no_move_ff <= csr_wdata[htdps_pkg::MOVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign stored = htdps_pkg::entry_type'(rd_data);
   assign same = (stored.tag == new_ff.tag);
   assign full_write = (new_ff.flag == exact_flag_ff) || !same || (new_ff.depth > stored.depth);
   assign move_write = (new_ff.move != no_move_ff) || !same;

   always_comb begin
      merged = stored;
      if (full_write) begin
         merged = new_ff;
      end else if (move_write) begin
         merged.move = new_ff.move;
      end
   end

   assign wr_addr = cmd.clr_write ? clr_ff : index_ff;
   assign wr_data = cmd.clr_write ? '0 : merged;

   htdps_ram #(
      .WIDTH(htdps_pkg::ENTRY_W),
      .DEPTH(htdps_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.clr_write | cmd.commit_store),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (index_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_entry_ff <= stored;
         rsp_hit_ff <= same;
         rsp_hit_move_ff <= same ? stored.move : no_move_ff;
      end
   end

   assign status.is_probe = (cmd_ff == htdps_pkg::CMD_PROBE);
   assign status.clr_last = (clr_ff == {htdps_pkg::INDEX_BITS{1'b1}});
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_entry_flag = rsp_entry_ff.flag;
   assign rsp_entry_move = rsp_entry_ff.move;
   assign rsp_hit_move = rsp_hit_move_ff;
   assign rsp_entry_depth = rsp_entry_ff.depth;
   assign rsp_entry_score = rsp_entry_ff.score;
   assign rsp_entry_eval = rsp_entry_ff.eval;

endmodule
`default_nettype wire

// File: tb/hash_table_depth_preferred_store_core_tb.sv
// testbench for hash_table_depth_preferred_store_core: directed rows, then random stores
// and probes under several register settings, probes checked vs a typed row or shadow table
// depends on htdps_pkg and the core rtl
module hash_table_depth_preferred_store_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int DIRECTED_ROWS = 19;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 10;
   localparam int INDEX_POOL = 6;
   localparam int TAG_POOL = 3;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic cmd;
      logic [htdps_pkg::KEY_W-1:0] key;
      logic [htdps_pkg::FLAG_W-1:0] flag;
      logic [htdps_pkg::MOVE_W-1:0] move;
      logic [htdps_pkg::DEPTH_W-1:0] depth;
      logic signed [htdps_pkg::SCORE_W-1:0] score;
      logic signed [htdps_pkg::SCORE_W-1:0] eval;
   } request_type;

   typedef struct packed {
      logic hit;
      logic [htdps_pkg::FLAG_W-1:0] flag;
      logic [htdps_pkg::MOVE_W-1:0] move;
      logic [htdps_pkg::MOVE_W-1:0] hit_move;
      logic [htdps_pkg::DEPTH_W-1:0] depth;
      logic signed [htdps_pkg::SCORE_W-1:0] score;
      logic signed [htdps_pkg::SCORE_W-1:0] eval;
   } probe_result_type;

   typedef struct packed {
      request_type req;
      logic typed;
      probe_result_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_cmd;
   logic [htdps_pkg::KEY_W-1:0] req_key;
   logic [htdps_pkg::FLAG_W-1:0] req_bound_flag;
   logic [htdps_pkg::MOVE_W-1:0] req_best_move;
   logic [htdps_pkg::DEPTH_W-1:0] req_search_depth;
   logic signed [htdps_pkg::SCORE_W-1:0] req_score_value;
   logic signed [htdps_pkg::SCORE_W-1:0] req_static_eval;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   logic [htdps_pkg::FLAG_W-1:0] rsp_entry_flag;
   logic [htdps_pkg::MOVE_W-1:0] rsp_entry_move;
   logic [htdps_pkg::MOVE_W-1:0] rsp_hit_move;
   logic [htdps_pkg::DEPTH_W-1:0] rsp_entry_depth;
   logic signed [htdps_pkg::SCORE_W-1:0] rsp_entry_score;
   logic signed [htdps_pkg::SCORE_W-1:0] rsp_entry_eval;
   logic csr_valid;
   logic csr_ready;
   logic [htdps_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [htdps_pkg::CSR_DATA_W-1:0] csr_wdata;

   htdps_pkg::entry_type shadow_table[htdps_pkg::TABLE_DEPTH];
   logic [htdps_pkg::FLAG_W-1:0] exact_flag_reg;
   logic [htdps_pkg::MOVE_W-1:0] no_move_reg;
   probe_result_type pending_probes[$];
   directed_row_type directed_rows[DIRECTED_ROWS];
   logic [htdps_pkg::INDEX_BITS-1:0] index_pool[INDEX_POOL];
   logic [htdps_pkg::TAG_W-1:0] tag_pool[TAG_POOL];
   bit idle_on;
   int hold_request;
   int stores_sent;
   int probes_sent;
   int results_checked;
   int failures;
   int settings_used;

   hash_table_depth_preferred_store_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_bound_flag   (req_bound_flag),
      .req_best_move    (req_best_move),
      .req_search_depth (req_search_depth),
      .req_score_value  (req_score_value),
      .req_static_eval  (req_static_eval),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_entry_flag   (rsp_entry_flag),
      .rsp_entry_move   (rsp_entry_move),
      .rsp_hit_move     (rsp_hit_move),
      .rsp_entry_depth  (rsp_entry_depth),
      .rsp_entry_score  (rsp_entry_score),
      .rsp_entry_eval   (rsp_entry_eval),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("hash_table_depth_preferred_store_core_tb NOT OK");
      $finish;
   end

   // returns 1 and the expected result for a probe, updates the shadow entry for a store
   function automatic logic apply_to_shadow_table(input request_type r,
                                                  output probe_result_type p);
      logic [htdps_pkg::INDEX_BITS-1:0] idx;
      logic [htdps_pkg::TAG_W-1:0] tag;
      logic same;
      htdps_pkg::entry_type e;
      idx = r.key[htdps_pkg::KEY_W-1 -: htdps_pkg::INDEX_BITS];
      tag = r.key[htdps_pkg::TAG_W-1:0];
      e = shadow_table[idx];
      same = (e.tag == tag);
      p = '0;
      if (r.cmd == htdps_pkg::CMD_STORE) begin
         if (r.move != no_move_reg || !same)
            e.move = r.move;
         if (r.flag == exact_flag_reg || !same || r.depth > e.depth)
            e = '{tag, r.flag, r.move, r.depth, r.score, r.eval};
         shadow_table[idx] = e;
         return 1'b0;
      end
      p = '{same, e.flag, e.move, same ? e.move : no_move_reg, e.depth, e.score, e.eval};
      return 1'b1;
   endfunction

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idle_on || pick < 80)
         return 0;
      if (pick < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int stall_burst();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idle_on || pick < 70)
         return 0;
      if (pick < 95)
         return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.cmd = $urandom_range(0, 1) ? htdps_pkg::CMD_PROBE : htdps_pkg::CMD_STORE;
      r.key = {$urandom, $urandom};
      // mostly a few entries and tags so stores and probes meet
      if ($urandom_range(0, 9) < 7) begin
         r.key[htdps_pkg::KEY_W-1 -: htdps_pkg::INDEX_BITS] =
            index_pool[$urandom_range(0, INDEX_POOL-1)];
         r.key[htdps_pkg::TAG_W-1:0] = tag_pool[$urandom_range(0, TAG_POOL-1)];
      end
      r.flag = htdps_pkg::FLAG_W'($urandom_range(0, 3));
      r.move = ($urandom_range(0, 2) == 0) ? no_move_reg : htdps_pkg::MOVE_W'($urandom);
      r.depth = $urandom_range(0, 1) ? htdps_pkg::DEPTH_W'($urandom_range(0, 15))
                                     : htdps_pkg::DEPTH_W'($urandom);
      r.score = htdps_pkg::SCORE_W'($urandom);
      r.eval = htdps_pkg::SCORE_W'($urandom);
      return r;
   endfunction

   task automatic send_item(input request_type r, input logic typed,
                            input probe_result_type want);
      probe_result_type predicted;
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_key <= r.key;
      req_bound_flag <= r.flag;
      req_best_move <= r.move;
      req_search_depth <= r.depth;
      req_score_value <= r.score;
      req_static_eval <= r.eval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (apply_to_shadow_table(r, predicted)) begin
         pending_probes.push_back(typed ? want : predicted);
         probes_sent++;
      end else begin
         stores_sent++;
      end
   endtask

   task automatic idle_sender();
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_probes.size() != 0) @(posedge clock);
   endtask

   task automatic write_registers(input logic [htdps_pkg::FLAG_W-1:0] exact,
                                  input logic [htdps_pkg::MOVE_W-1:0] no_move);
      csr_valid <= 1'b1;
      for (int i = 0; i < 2; i++) begin
         csr_index <= (i == 0) ? htdps_pkg::CSR_EXACT_FLAG : htdps_pkg::CSR_NO_MOVE;
         csr_wdata <= (i == 0) ? htdps_pkg::CSR_DATA_W'(exact) : no_move;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (i == 0)
            exact_flag_reg = exact;
         else
            no_move_reg = no_move;
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // result side: checks accepted items and drives stall
   initial begin
      int stall_left;
      probe_result_type got;
      probe_result_type want;
      rsp_stall <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = '{rsp_hit, rsp_entry_flag, rsp_entry_move, rsp_hit_move,
                    rsp_entry_depth, rsp_entry_score, rsp_entry_eval};
            results_checked++;
            if (pending_probes.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: result item with no probe outstanding", $time);
            end else begin
               want = pending_probes.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("%0t: probe result mismatch", $time);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
               end
            end
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (stall_left == 0) begin
            stall_left = stall_burst();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [htdps_pkg::FLAG_W-1:0] exact;
      logic [htdps_pkg::MOVE_W-1:0] no_move;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= htdps_pkg::CMD_STORE;
      req_key <= '0;
      req_bound_flag <= '0;
      req_best_move <= '0;
      req_search_depth <= '0;
      req_score_value <= '0;
      req_static_eval <= '0;
      csr_valid <= 1'b0;
      csr_index <= htdps_pkg::CSR_EXACT_FLAG;
      csr_wdata <= '0;
      for (int i = 0; i < htdps_pkg::TABLE_DEPTH; i++)
         shadow_table[i] = '0;
      exact_flag_reg = '0;
      no_move_reg = '0;
      idle_on = 1'b1;
      hold_request = 0;
      stores_sent = 0;
      probes_sent = 0;
      results_checked = 0;
      failures = 0;
      settings_used = 1;

      // empty table after reset: tag zero hits, anything else misses
      directed_rows[0] = '{
         '{htdps_pkg::CMD_PROBE, 64'h0, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b1, '{1'b1, 2'd0, 16'h0000, 16'h0000, 8'd0, 16'h0000, 16'h0000}};
      directed_rows[1] = '{
         '{htdps_pkg::CMD_PROBE, '1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b1, '{1'b0, 2'd0, 16'h0000, 16'h0000, 8'd0, 16'h0000, 16'h0000}};
      directed_rows[2] = '{
         '{htdps_pkg::CMD_STORE, '1, 2'd3, 16'hFFFF, 8'd255, 16'h7FFF, 16'h8000},
         1'b0, '0};
      directed_rows[3] = '{
         '{htdps_pkg::CMD_PROBE, '1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b1, '{1'b1, 2'd3, 16'hFFFF, 16'hFFFF, 8'd255, 16'h7FFF, 16'h8000}};
      // same tag, shallower: move only
      directed_rows[4] = '{
         '{htdps_pkg::CMD_STORE, '1, 2'd1, 16'h1234, 8'd0, 16'h1111, 16'h2222},
         1'b0, '0};
      directed_rows[5] = '{
         '{htdps_pkg::CMD_PROBE, '1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};
      // depth tie with the no-move code: entry kept
      directed_rows[6] = '{
         '{htdps_pkg::CMD_STORE, '1, 2'd2, 16'h0000, 8'd255, 16'h0000, 16'h0000},
         1'b0, '0};
      directed_rows[7] = '{
         '{htdps_pkg::CMD_PROBE, '1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};
      // exact flag forces overwrite
      directed_rows[8] = '{
         '{htdps_pkg::CMD_STORE, '1, 2'd0, 16'h0000, 8'd0, 16'h8000, 16'h7FFF},
         1'b0, '0};
      directed_rows[9] = '{
         '{htdps_pkg::CMD_PROBE, '1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};
      directed_rows[10] = '{
         '{htdps_pkg::CMD_STORE, 64'h0, 2'd1, 16'h0000, 8'd1, 16'hFFFF, 16'h0001},
         1'b0, '0};
      directed_rows[11] = '{
         '{htdps_pkg::CMD_PROBE, 64'h0, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};
      directed_rows[12] = '{
         '{htdps_pkg::CMD_PROBE, 64'h1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};
      // tag differs: whole entry replaced even with the no-move code
      directed_rows[13] = '{
         '{htdps_pkg::CMD_STORE, 64'h1, 2'd2, 16'h0000, 8'd0, 16'h0123, 16'hFEDC},
         1'b0, '0};
      directed_rows[14] = '{
         '{htdps_pkg::CMD_PROBE, 64'h1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};
      directed_rows[15] = '{
         '{htdps_pkg::CMD_STORE, 64'h1, 2'd3, 16'h0000, 8'd0, 16'h4444, 16'h5555},
         1'b0, '0};
      directed_rows[16] = '{
         '{htdps_pkg::CMD_PROBE, 64'hAAAA_5555_AAAA_5555, 2'd3, 16'hFFFF, 8'd255,
           16'h7FFF, 16'h8000},
         1'b1, '{1'b0, 2'd0, 16'h0000, 16'h0000, 8'd0, 16'h0000, 16'h0000}};
      directed_rows[17] = '{
         '{htdps_pkg::CMD_PROBE, 64'h0010_0000_0000_0000, 2'd0, 16'h0000, 8'd0,
           16'h0000, 16'h0000},
         1'b1, '{1'b1, 2'd0, 16'h0000, 16'h0000, 8'd0, 16'h0000, 16'h0000}};
      directed_rows[18] = '{
         '{htdps_pkg::CMD_PROBE, 64'h1, 2'd0, 16'h0000, 8'd0, 16'h0000, 16'h0000},
         1'b0, '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         idle_sender();
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (ph)
            0: begin exact = 2'd3; no_move = 16'hFFFF; end
            1: begin exact = 2'd0; no_move = htdps_pkg::MOVE_W'($urandom); end
            2: begin exact = 2'd2; no_move = 16'h0000; end
            3: begin exact = 2'd1; no_move = htdps_pkg::MOVE_W'($urandom); end
            4: begin exact = 2'd0; no_move = 16'hFFFF; end
            default: begin exact = 2'd3; no_move = htdps_pkg::MOVE_W'($urandom); end
         endcase
         write_registers(exact, no_move);
         index_pool[0] = '0;
         index_pool[1] = '1;
         for (int i = 2; i < INDEX_POOL; i++)
            index_pool[i] = htdps_pkg::INDEX_BITS'($urandom);
         tag_pool[0] = '0;
         for (int i = 1; i < TAG_POOL; i++)
            tag_pool[i] = htdps_pkg::TAG_W'($urandom);
         idle_on = (ph != 2);
         if (ph == 0)
            hold_request = LONG_HOLD;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 3 && n == ITEMS_PER_PHASE / 2)
               drain_results();
            send_item(random_request(), 1'b0, '0);
            idle_sender();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d stores and %0d probes under %0d register settings",
               stores_sent, probes_sent, settings_used);
      $display("%0d result items compared, %0d failures", results_checked, failures);
      if (failures == 0)
         $display("hash_table_depth_preferred_store_core_tb OK");
      else
         $display("hash_table_depth_preferred_store_core_tb NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
src/htdps_pkg.sv
src/htdps_ram.sv
src/htdps_ctrl.sv
src/htdps_dp.sv
src/hash_table_depth_preferred_store_core.sv
tb/hash_table_depth_preferred_store_core_tb.sv
